// ----- rtl/core/rfp_pkg.sv -----
// Shared types and constants of the ROI readout frame parser.
package rfp_pkg;

	localparam int WORD_W  = 16;
	localparam int POS_W   = 9;
	localparam int HITS_W  = 17;
	localparam int TIME_W  = 32;
	localparam int STAT_W  = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [WORD_W-1:0] SYNC_WORD  = 16'hFFFF;
	localparam logic [WORD_W-1:0] CLIP_RESET = 16'd4000;
	localparam logic [HITS_W-1:0] HITS_MAX   = 17'h1FFFF;

	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_OOB   = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LIMIT      = 1'd1;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [WORD_W-1:0]    data;
	} cfg_wr_t;

	typedef struct packed {
		logic              pixel_valid;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [WORD_W-1:0] pixel_value;
		logic              over_threshold;
		logic              frame_end;
		logic [STAT_W-1:0] frame_status;
		logic [HITS_W-1:0] hit_count;
		logic [WORD_W-1:0] buffer_id;
		logic [TIME_W-1:0] time_ticks;
	} res_t;

endpackage

// ----- rtl/core/rfp_if.sv -----
// Stream interfaces: readout words in, parsed pixel results out.
interface rfp_word_if;
	logic                       valid;
	logic                       ready;
	logic [rfp_pkg::WORD_W-1:0] word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

interface rfp_result_if;
	logic                       valid;
	logic                       ready;
	logic                       pixel_valid;
	logic [rfp_pkg::POS_W-1:0]  pos_x;
	logic [rfp_pkg::POS_W-1:0]  pos_y;
	logic [rfp_pkg::WORD_W-1:0] pixel_value;
	logic                       over_threshold;
	logic                       frame_end;
	logic [rfp_pkg::STAT_W-1:0] frame_status;
	logic [rfp_pkg::HITS_W-1:0] hit_count;
	logic [rfp_pkg::WORD_W-1:0] buffer_id;
	logic [rfp_pkg::TIME_W-1:0] time_ticks;

	modport source (output valid, output pixel_valid, output pos_x, output pos_y,
		output pixel_value, output over_threshold, output frame_end,
		output frame_status, output hit_count, output buffer_id, output time_ticks,
		input ready);
	modport sink (input valid, input pixel_valid, input pos_x, input pos_y,
		input pixel_value, input over_threshold, input frame_end,
		input frame_status, input hit_count, input buffer_id, input time_ticks,
		output ready);
endinterface

// ----- rtl/core/rfp_parser.sv -----
// Frame parser: header decode, ROI scan and per-word result register.
module rfp_parser #(
	parameter int X_SIZE = 352,
	parameter int Y_SIZE = 300
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rfp_pkg::cfg_wr_t           cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rfp_pkg::WORD_W-1:0] word,
	output logic                       res_valid,
	input  logic                       res_ready,
	output rfp_pkg::res_t              res
);

	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_ROI   = 3'd1;
	localparam logic [2:0] PH_BUF   = 3'd2;
	localparam logic [2:0] PH_T1    = 3'd3;
	localparam logic [2:0] PH_T2    = 3'd4;
	localparam logic [2:0] PH_DUMMY = 3'd5;
	localparam logic [2:0] PH_PIX   = 3'd6;

	localparam logic [rfp_pkg::WORD_W-1:0] X_LAST = rfp_pkg::WORD_W'(X_SIZE - 1);
	localparam logic [rfp_pkg::WORD_W-1:0] Y_LAST = rfp_pkg::WORD_W'(Y_SIZE - 1);

	logic [rfp_pkg::WORD_W-1:0] thr_q, clip_q;

	logic [2:0]                 phase_q, phase_d;
	logic [1:0]                 hdr_q, hdr_d;
	logic [rfp_pkg::WORD_W-1:0] ymin_q, ymax_q, xmin_q, xmax_q;
	logic [rfp_pkg::WORD_W-1:0] ymin_d, ymax_d, xmin_d, xmax_d;
	logic [rfp_pkg::WORD_W-1:0] sx_q, sy_q, sx_d, sy_d;
	logic                       reject_q, reject_d;
	logic [rfp_pkg::HITS_W-1:0] hits_q, hits_d;
	logic [rfp_pkg::WORD_W-1:0] bufid_q, bufid_d;
	logic [rfp_pkg::WORD_W-1:0] tlow_q, tlow_d;
	logic [rfp_pkg::TIME_W-1:0] time_q, time_d;

	logic          emit;
	rfp_pkg::res_t res_d;
	logic          in_fire;
	logic          last, hit;
	logic          res_valid_s1;
	rfp_pkg::res_t res_s1;

	assign in_ready  = !res_valid_s1 || res_ready;
	assign in_fire   = in_valid && in_ready;
	assign res_valid = res_valid_s1;
	assign res       = res_s1;

	assign last = (sx_q == xmax_q) && (sy_q == ymax_q);
	assign hit  = word > thr_q;

	always_comb begin
		phase_d  = phase_q;
		hdr_d    = hdr_q;
		ymin_d   = ymin_q;
		ymax_d   = ymax_q;
		xmin_d   = xmin_q;
		xmax_d   = xmax_q;
		sx_d     = sx_q;
		sy_d     = sy_q;
		reject_d = reject_q;
		hits_d   = hits_q;
		bufid_d  = bufid_q;
		tlow_d   = tlow_q;
		time_d   = time_q;
		emit     = 1'b0;
		res_d    = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (word == rfp_pkg::SYNC_WORD) begin
					phase_d = PH_ROI;
					hdr_d   = 2'd0;
				end
			end
			PH_ROI: begin
				unique case (hdr_q)
					2'd0: ymin_d = word;
					2'd1: ymax_d = word;
					2'd2: xmin_d = word;
					default: xmax_d = word;
				endcase
				if (hdr_q != 2'd3) begin
					hdr_d = hdr_q + 2'd1;
				end else begin
					hdr_d = 2'd0;
					if ((ymax_q < ymin_q) || (word < xmin_q)) begin
						emit               = 1'b1;
						res_d.frame_end    = 1'b1;
						res_d.frame_status = rfp_pkg::STATUS_EMPTY;
						phase_d            = PH_HUNT;
					end else begin
						reject_d = (ymax_q > Y_LAST) || (word > X_LAST);
						phase_d  = PH_BUF;
					end
				end
			end
			PH_BUF: begin
				bufid_d = word;
				phase_d = PH_T1;
			end
			PH_T1: begin
				tlow_d  = word;
				phase_d = PH_T2;
			end
			PH_T2: begin
				// time1 + time2 * 65534, kept modulo 2^32
				time_d  = {16'd0, tlow_q} + {word, 16'd0} - {15'd0, word, 1'b0};
				phase_d = PH_DUMMY;
				hdr_d   = 2'd0;
			end
			PH_DUMMY: begin
				if (hdr_q == 2'd0) begin
					hdr_d = 2'd1;
				end else begin
					hdr_d   = 2'd0;
					sx_d    = xmin_q;
					sy_d    = ymin_q;
					hits_d  = '0;
					phase_d = PH_PIX;
				end
			end
			PH_PIX: begin
				if (!reject_q) begin
					if (hit && (hits_q != rfp_pkg::HITS_MAX)) begin
						hits_d = hits_q + rfp_pkg::HITS_W'(1);
					end
					res_d.pixel_valid    = 1'b1;
					res_d.pos_x          = sx_q[rfp_pkg::POS_W-1:0];
					res_d.pos_y          = sy_q[rfp_pkg::POS_W-1:0];
					res_d.pixel_value    = (word > clip_q) ? '0 : word;
					res_d.over_threshold = hit;
				end
				if (sy_q == ymax_q) begin
					sy_d = ymin_q;
					sx_d = sx_q + rfp_pkg::WORD_W'(1);
				end else begin
					sy_d = sy_q + rfp_pkg::WORD_W'(1);
				end
				emit = !reject_q;
				if (last) begin
					emit               = 1'b1;
					res_d.frame_end    = 1'b1;
					res_d.frame_status = reject_q ? rfp_pkg::STATUS_OOB : rfp_pkg::STATUS_OK;
					res_d.hit_count    = reject_q ? '0 : hits_d;
					res_d.buffer_id    = bufid_q;
					res_d.time_ticks   = time_q;
					phase_d            = PH_HUNT;
				end
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			clip_q <= rfp_pkg::CLIP_RESET;
		end else if (cfg.we) begin
			unique case (cfg.index)
				rfp_pkg::CFG_PIXEL_THRESHOLD: thr_q  <= cfg.data;
				rfp_pkg::CFG_CLIP_LIMIT:      clip_q <= cfg.data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			hdr_q    <= '0;
			ymin_q   <= '0;
			ymax_q   <= '0;
			xmin_q   <= '0;
			xmax_q   <= '0;
			sx_q     <= '0;
			sy_q     <= '0;
			reject_q <= 1'b0;
			hits_q   <= '0;
			bufid_q  <= '0;
			tlow_q   <= '0;
			time_q   <= '0;
		end else if (in_fire) begin
			phase_q  <= phase_d;
			hdr_q    <= hdr_d;
			ymin_q   <= ymin_d;
			ymax_q   <= ymax_d;
			xmin_q   <= xmin_d;
			xmax_q   <= xmax_d;
			sx_q     <= sx_d;
			sy_q     <= sy_d;
			reject_q <= reject_d;
			hits_q   <= hits_d;
			bufid_q  <= bufid_d;
			tlow_q   <= tlow_d;
			time_q   <= time_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			res_valid_s1 <= in_fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_s1 <= res_d;
		end
	end

endmodule

// ----- rtl/core/rfp_skid.sv -----
// Two-word output buffer between the parser result register and the port.
module rfp_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rfp_pkg::res_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rfp_pkg::res_t out_data
);

	rfp_pkg::res_t mem_q [2];
	logic [1:0]    count_q;
	logic          wr_ptr_q, rd_ptr_q;
	logic          push, pop;

	assign in_ready  = count_q != 2'd2;
	assign out_valid = count_q != 2'd0;
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_data;
	end

endmodule

// ----- rtl/core/roi_readout_frame_parser.sv -----
// Top level of the ROI readout frame parser.
//
//  channel  | dir | word content
//  ---------+-----+-------------------------------------------------------
//  stream   | in  | one 16-bit readout word
//  result   | out | pixel coords/value/flag, frame end summary
//  cfg_*    | in  | register write: 0 pixel_threshold, 1 clip_limit
//
// One word per cycle sustained unless the output stalls; each word is decoded
// into the result register, then passes a two-word buffer. Header words and
// rejected pixels give no word out, but for the frame end word of an empty
// ROI or rejected frame. Reset clears state to sync hunt and clip_limit to 4000.
// A stalled output fills the buffer and result register before the input stalls.
module roi_readout_frame_parser #(
	parameter int X_SIZE = 352,
	parameter int Y_SIZE = 300
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rfp_pkg::WORD_W-1:0]    cfg_data,
	rfp_word_if.sink                      stream,
	rfp_result_if.source                  result
);

	rfp_pkg::cfg_wr_t cfg;
	logic             core_valid, core_ready;
	rfp_pkg::res_t    core_res, out_res;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	rfp_parser #(
		.X_SIZE(X_SIZE),
		.Y_SIZE(Y_SIZE)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (stream.valid),
		.in_ready  (stream.ready),
		.word      (stream.word),
		.res_valid (core_valid),
		.res_ready (core_ready),
		.res       (core_res)
	);

	rfp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (core_valid),
		.in_ready  (core_ready),
		.in_data   (core_res),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (out_res)
	);

	assign result.pixel_valid    = out_res.pixel_valid;
	assign result.pos_x          = out_res.pos_x;
	assign result.pos_y          = out_res.pos_y;
	assign result.pixel_value    = out_res.pixel_value;
	assign result.over_threshold = out_res.over_threshold;
	assign result.frame_end      = out_res.frame_end;
	assign result.frame_status   = out_res.frame_status;
	assign result.hit_count      = out_res.hit_count;
	assign result.buffer_id      = out_res.buffer_id;
	assign result.time_ticks     = out_res.time_ticks;

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.frame_status == rfp_pkg::STATUS_EMPTY)
		|-> result.frame_end && !result.pixel_valid && (result.time_ticks == '0))
		else $error("empty-ROI word carries pixel or summary data");

	a_oob_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.frame_status == rfp_pkg::STATUS_OOB)
		|-> result.frame_end && !result.pixel_valid && (result.hit_count == '0))
		else $error("rejected frame emitted pixel data");

	a_mid_frame_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.frame_end
		|-> result.pixel_valid && (result.frame_status == rfp_pkg::STATUS_OK)
			&& (result.hit_count == '0) && (result.time_ticks == '0))
		else $error("non-final word carries frame summary");

	a_core_hold: assert property (@(posedge clk) disable iff (!arst_n)
		core_valid && !core_ready |=> core_valid && $stable(core_res))
		else $error("parser result changed while buffer was full");

endmodule
